[rtl/sms_pkg.sv]
`default_nettype none

package sms_pkg;

	// Longest transfer in bits and the counter widths that follow from it.
	localparam int WORD_BITS = 32;
	localparam int CNT_W     = $clog2(WORD_BITS + 1);
	localparam int IDX_W     = $clog2(WORD_BITS);

	// Fixed field widths of the stream payloads.
	localparam int DATA_W    = 32;
	localparam int BITCNT_W  = 6;
	localparam int CFG_IDX_W = 3;
	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 40;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_POLARITY  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_PHASE     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SELECT_POLARITY = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SELECT_PRESENT  = 3'd3;

	// Request kinds carried in tuser.
	localparam logic REQ_TICK  = 1'b0;
	localparam logic REQ_START = 1'b1;

	// One input request.
	typedef struct packed {
		logic                req_type;
		logic [DATA_W-1:0]   write_data;
		logic [BITCNT_W-1:0] xfer_len;
		logic                miso_level;
	} item_t;

	// One result.
	typedef struct packed {
		logic              sclk_level;
		logic              mosi_level;
		logic              select_level;
		logic              busy_res;
		logic              done_res;
		logic [DATA_W-1:0] read_data;
	} res_t;

endpackage

`default_nettype wire

[rtl/sms_core.sv]
`default_nettype none

module sms_core (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              item_valid,
	input  sms_pkg::item_t                   item,
	input  wire                              cfg_wr,
	input  wire [sms_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire                              cfg_data,
	output sms_pkg::res_t                    res
);

	// Configuration registers.
	logic cpol_q, cpha_q, spol_q, spres_q;

	// Transfer state.
	logic [sms_pkg::WORD_BITS-1:0] out_shift_q, in_shift_q;
	logic [sms_pkg::CNT_W-1:0]     bits_left_q;
	logic                          edge_q, active_q, clock_q, mosi_q, sel_q;

	logic [sms_pkg::WORD_BITS-1:0] out_shift_n, in_shift_n;
	logic [sms_pkg::CNT_W-1:0]     bits_left_n;
	logic                          edge_n, active_n, clock_n, mosi_n, sel_n;
	logic                          cpol_n, cpha_n, spol_n, spres_n;
	logic                          done_n;
	logic [sms_pkg::CNT_W-1:0]     count;

	// Next state for one request: start, leading edge or trailing edge.
	always_comb begin
		out_shift_n = out_shift_q;
		in_shift_n  = in_shift_q;
		bits_left_n = bits_left_q;
		edge_n      = edge_q;
		active_n    = active_q;
		clock_n     = clock_q;
		mosi_n      = mosi_q;
		sel_n       = sel_q;
		done_n      = 1'b0;
		count       = '0;

		if (item_valid) begin
			if (item.req_type == sms_pkg::REQ_START) begin
				if (!active_q) begin
					// Clamp the bit count to one through a full word.
					if (item.xfer_len == '0) begin
						count = sms_pkg::CNT_W'(1);
					end else if (int'(item.xfer_len) > sms_pkg::WORD_BITS) begin
						count = sms_pkg::CNT_W'(sms_pkg::WORD_BITS);
					end else begin
						count = sms_pkg::CNT_W'(item.xfer_len);
					end
					out_shift_n = sms_pkg::WORD_BITS'(item.write_data);
					in_shift_n  = '0;
					bits_left_n = count;
					edge_n      = 1'b0;
					active_n    = 1'b1;
					clock_n     = cpol_q;
					if (spres_q) begin
						sel_n = spol_q;
					end
					// Phase 0 puts the first bit out before the first edge.
					if (!cpha_q) begin
						mosi_n = out_shift_n[sms_pkg::IDX_W'(count - sms_pkg::CNT_W'(1))];
					end
				end
			end else if (active_q) begin
				if (!edge_q) begin
					// Leading edge: clock leaves idle.
					clock_n = !cpol_q;
					if (!cpha_q && bits_left_n != '0) begin
						in_shift_n  = {in_shift_q[sms_pkg::WORD_BITS-2:0], item.miso_level};
						bits_left_n = bits_left_q - sms_pkg::CNT_W'(1);
					end
					if (bits_left_n != '0) begin
						mosi_n = out_shift_q[sms_pkg::IDX_W'(bits_left_n - sms_pkg::CNT_W'(1))];
					end
					edge_n = 1'b1;
				end else begin
					// Trailing edge: clock returns to idle, phase 1 samples.
					clock_n = cpol_q;
					if (cpha_q && bits_left_q != '0) begin
						in_shift_n  = {in_shift_q[sms_pkg::WORD_BITS-2:0], item.miso_level};
						bits_left_n = bits_left_q - sms_pkg::CNT_W'(1);
					end
					edge_n = 1'b0;
					if (bits_left_n == '0) begin
						active_n = 1'b0;
						sel_n    = !spol_q;
						done_n   = 1'b1;
					end
				end
			end
		end

		// Register writes; an idle line with no request follows the new settings at once.
		cpol_n  = cpol_q;
		cpha_n  = cpha_q;
		spol_n  = spol_q;
		spres_n = spres_q;
		if (cfg_wr) begin
			unique case (cfg_index)
				sms_pkg::CFG_CLOCK_POLARITY:  cpol_n  = cfg_data;
				sms_pkg::CFG_CLOCK_PHASE:     cpha_n  = cfg_data;
				sms_pkg::CFG_SELECT_POLARITY: spol_n  = cfg_data;
				sms_pkg::CFG_SELECT_PRESENT:  spres_n = cfg_data;
				default: ;
			endcase
			if (!active_q && !item_valid) begin
				clock_n = cpol_n;
				sel_n   = !spol_n;
			end
		end
	end

	// Result of the request just taken.
	always_comb begin
		res.sclk_level   = clock_n;
		res.mosi_level   = mosi_n;
		res.select_level = sel_n;
		res.busy_res     = active_n;
		res.done_res     = done_n;
		res.read_data    = done_n ? sms_pkg::DATA_W'(in_shift_n) : '0;
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpol_q      <= 1'b0;
			cpha_q      <= 1'b0;
			spol_q      <= 1'b0;
			spres_q     <= 1'b1;
			bits_left_q <= '0;
			edge_q      <= 1'b0;
			active_q    <= 1'b0;
			clock_q     <= 1'b0;
			mosi_q      <= 1'b0;
			sel_q       <= 1'b1;
			out_shift_q <= '0;
			in_shift_q  <= '0;
		end else begin
			cpol_q      <= cpol_n;
			cpha_q      <= cpha_n;
			spol_q      <= spol_n;
			spres_q     <= spres_n;
			bits_left_q <= bits_left_n;
			edge_q      <= edge_n;
			active_q    <= active_n;
			clock_q     <= clock_n;
			mosi_q      <= mosi_n;
			sel_q       <= sel_n;
			out_shift_q <= out_shift_n;
			in_shift_q  <= in_shift_n;
		end
	end

	// While idle, the clock rests at its polarity and select is released.
	a_idle_clock: assert property (@(posedge clk) disable iff (!arst_n)
		!active_q |-> clock_q == cpol_q)
		else $error("idle clock level differs from polarity");

	a_idle_select: assert property (@(posedge clk) disable iff (!arst_n)
		!active_q |-> sel_q == !spol_q)
		else $error("select not released while idle");

	a_bits_range: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> bits_left_q <= sms_pkg::CNT_W'(sms_pkg::WORD_BITS))
		else $error("bit counter beyond word size");

	a_done_ends: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && res.done_res |=> !active_q && bits_left_q == '0)
		else $error("transfer reported done but still running");

endmodule

`default_nettype wire

[rtl/sms_out_buf.sv]
`default_nettype none

module sms_out_buf (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            in_valid,
	output logic           in_ready,
	input  sms_pkg::res_t  in_res,
	output logic           out_valid,
	input  wire            out_ready,
	output sms_pkg::res_t  out_res
);

	logic          main_valid_q, skid_valid_q;
	sms_pkg::res_t main_q, skid_q;
	logic          push, pop;

	assign in_ready  = !skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_res   = main_q;
	assign push      = in_valid && in_ready;
	assign pop       = main_valid_q && out_ready;

	// Valid flags of the output register and the skid stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (skid_valid_q) begin
				if (pop) begin
					skid_valid_q <= 1'b0;
				end
			end else if (push) begin
				if (main_valid_q && !pop) begin
					skid_valid_q <= 1'b1;
				end else begin
					main_valid_q <= 1'b1;
				end
			end else if (pop) begin
				main_valid_q <= 1'b0;
			end
		end
	end

	// Payload moves: skid refills the output, else a new result lands.
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				main_q <= skid_q;
			end
		end else if (push) begin
			if (main_valid_q && !pop) begin
				skid_q <= in_res;
			end else begin
				main_q <= in_res;
			end
		end
	end

endmodule

`default_nettype wire

[rtl/spi_master_shifter_unit.sv]
// SPI master shifter for clock polarity and phase modes 0 to 3.
//
// The input stream carries requests: tuser selects a start (1) or a tick (0).
// A start loads write_data and xfer_len and opens a transfer; each tick is
// one half period of the serial clock and carries the sampled MISO level.
// Every request yields exactly one result on the output stream with the
// clock, MOSI and select line levels, busy, and done (on tlast) together
// with the collected read word, right aligned.
// Each result is registered in the output register or the skid stage, and
// a request can be accepted in every cycle while the skid stage is empty.
// The output register plus a one-entry skid stage let a new request enter
// while a result waits; s_tready drops only when both hold results.
// Configuration writes are accepted every cycle and are meant for idle time.
// Reset clears the transfer, returns all registers to their defaults (clock
// idle low, phase 0, select active low and present), and empties the output.
`default_nettype none

module spi_master_shifter_unit (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        s_tvalid,
	output logic       s_tready,
	// write_data[31:0], xfer_len[37:32], miso_level[38], zero[39]
	input  wire [sms_pkg::S_TDATA_W-1:0] s_tdata,
	// req_type[0]
	input  wire        s_tuser,
	output logic       m_tvalid,
	input  wire        m_tready,
	// sclk_level[0], mosi_level[1], select_level[2], busy_res[3],
	// read_data[35:4], zero[39:36]
	output logic [sms_pkg::M_TDATA_W-1:0] m_tdata,
	// done_res
	output logic       m_tlast,
	input  wire        cfg_valid,
	output logic       cfg_ready,
	input  wire [sms_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire        cfg_data
);

	sms_pkg::item_t item;
	sms_pkg::res_t  core_res, out_res;
	logic           item_valid;

	assign cfg_ready  = 1'b1;
	assign item_valid = s_tvalid && s_tready;

	// Unpack the request.
	always_comb begin
		item.req_type   = s_tuser;
		item.write_data = s_tdata[31:0];
		item.xfer_len   = s_tdata[37:32];
		item.miso_level = s_tdata[38];
	end

	sms_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item       (item),
		.cfg_wr     (cfg_valid && cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.res        (core_res)
	);

	sms_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item_valid),
		.in_ready  (s_tready),
		.in_res    (core_res),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (out_res)
	);

	// Pack the result.
	assign m_tdata = {4'b0000, out_res.read_data, out_res.busy_res,
		out_res.select_level, out_res.mosi_level, out_res.sclk_level};
	assign m_tlast = out_res.done_res;

endmodule

`default_nettype wire

[dv/spi_line_checker.sv]
`timescale 1ns / 1ps

// Watches the request, result and configuration channels of the SPI shifter,
// predicts the line levels for every accepted request and compares them with
// the results in order.
module spi_line_checker (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        s_tvalid,
	input  wire        s_tready,
	// write_data[31:0], xfer_len[37:32], miso_level[38], zero[39]
	input  wire [39:0] s_tdata,
	// req_type[0]
	input  wire        s_tuser,
	input  wire        m_tvalid,
	input  wire        m_tready,
	// sclk_level[0], mosi_level[1], select_level[2], busy_res[3],
	// read_data[35:4], zero[39:36]
	input  wire [39:0] m_tdata,
	// done_res
	input  wire        m_tlast,
	input  wire        cfg_valid,
	input  wire        cfg_ready,
	input  wire [2:0]  cfg_index,
	input  wire        cfg_data,
	output wire [31:0] mismatches,
	output logic [31:0] pending
);

	localparam int PRINT_LIMIT = 40;

	// Mode registers as the block should hold them.
	logic cpol, cpha, sel_pol, sel_on;

	// Transfer state and the driven line levels.
	logic [sms_pkg::DATA_W-1:0]   tx_word;
	logic [sms_pkg::DATA_W-1:0]   rx_word;
	logic [sms_pkg::BITCNT_W-1:0] bits_left;
	logic                         trailing;
	logic                         busy;
	logic                         sclk_q, mosi_q, sel_q;

	sms_pkg::res_t expected_lines[$];
	int            error_count = 0;

	assign mismatches = error_count;

	task automatic report_mismatch(input string msg);
		if (error_count < PRINT_LIMIT)
			$display("ERROR at %0t ns: %s", $realtime, msg);
		error_count++;
	endtask

	// Put the bit that goes out next on MOSI.
	function automatic void present_next_bit();
		if (bits_left != 0)
			mosi_q = tx_word[bits_left - 1];
	endfunction

	// Shift the sampled MISO level into the read word.
	function automatic void capture_miso(input logic miso);
		if (bits_left != 0) begin
			rx_word = {rx_word[sms_pkg::DATA_W-2:0], miso};
			bits_left--;
		end
	endfunction

	function automatic void apply_setting(input logic [sms_pkg::CFG_IDX_W-1:0] idx,
			input logic v);
		case (idx)
			sms_pkg::CFG_CLOCK_POLARITY: cpol = v;
			sms_pkg::CFG_CLOCK_PHASE: cpha = v;
			sms_pkg::CFG_SELECT_POLARITY: sel_pol = v;
			sms_pkg::CFG_SELECT_PRESENT: sel_on = v;
			default: return;
		endcase
		// An idle master follows the new idle levels at once.
		if (!busy) begin
			sclk_q = cpol;
			sel_q = ~sel_pol;
		end
	endfunction

	// Advance the transfer by one request and return the resulting line levels.
	function automatic sms_pkg::res_t next_line_levels(input logic kind,
			input logic [sms_pkg::DATA_W-1:0] word,
			input logic [sms_pkg::BITCNT_W-1:0] count, input logic miso);
		sms_pkg::res_t r;
		r = '0;
		if (kind == sms_pkg::REQ_START) begin
			if (!busy) begin
				tx_word = word;
				rx_word = '0;
				if (count == 0)
					bits_left = 1;
				else if (count > sms_pkg::WORD_BITS)
					bits_left = sms_pkg::BITCNT_W'(sms_pkg::WORD_BITS);
				else
					bits_left = count;
				trailing = 1'b0;
				busy = 1'b1;
				sclk_q = cpol;
				if (sel_on)
					sel_q = sel_pol;
				if (!cpha)
					present_next_bit();
			end
		end else if (busy) begin
			if (!trailing) begin
				// Leading edge.
				sclk_q = ~cpol;
				if (!cpha)
					capture_miso(miso);
				present_next_bit();
				trailing = 1'b1;
			end else begin
				// Trailing edge: the transfer ends once every bit is in.
				sclk_q = cpol;
				if (cpha)
					capture_miso(miso);
				trailing = 1'b0;
				if (bits_left == 0) begin
					busy = 1'b0;
					sel_q = ~sel_pol;
					r.done_res = 1'b1;
					r.read_data = rx_word;
				end
			end
		end
		r.sclk_level = sclk_q;
		r.mosi_level = mosi_q;
		r.select_level = sel_q;
		r.busy_res = busy;
		return r;
	endfunction

	task automatic compare_result(input sms_pkg::res_t want, input sms_pkg::res_t got);
		if (got.sclk_level !== want.sclk_level)
			report_mismatch($sformatf("sclk_level expected %0b, got %0b",
				want.sclk_level, got.sclk_level));
		if (got.mosi_level !== want.mosi_level)
			report_mismatch($sformatf("mosi_level expected %0b, got %0b",
				want.mosi_level, got.mosi_level));
		if (got.select_level !== want.select_level)
			report_mismatch($sformatf("select_level expected %0b, got %0b",
				want.select_level, got.select_level));
		if (got.busy_res !== want.busy_res)
			report_mismatch($sformatf("busy_res expected %0b, got %0b",
				want.busy_res, got.busy_res));
		if (got.done_res !== want.done_res)
			report_mismatch($sformatf("done_res expected %0b, got %0b",
				want.done_res, got.done_res));
		if (got.read_data !== want.read_data)
			report_mismatch($sformatf("read_data expected %08h, got %08h",
				want.read_data, got.read_data));
	endtask

	// Compare finished results first, then take in new settings and requests.
	always @(posedge clk or negedge arst_n) begin : watch
		sms_pkg::res_t got;
		sms_pkg::res_t want;
		if (!arst_n) begin
			cpol = 1'b0;
			cpha = 1'b0;
			sel_pol = 1'b0;
			sel_on = 1'b1;
			tx_word = '0;
			rx_word = '0;
			bits_left = '0;
			trailing = 1'b0;
			busy = 1'b0;
			sclk_q = 1'b0;
			mosi_q = 1'b0;
			sel_q = 1'b1;
			expected_lines.delete();
			pending <= '0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.sclk_level = m_tdata[0];
				got.mosi_level = m_tdata[1];
				got.select_level = m_tdata[2];
				got.busy_res = m_tdata[3];
				got.done_res = m_tlast;
				got.read_data = m_tdata[35:4];
				if (expected_lines.size() == 0) begin
					report_mismatch("result arrived with no request waiting for it");
				end else begin
					want = expected_lines.pop_front();
					compare_result(want, got);
				end
			end
			if (cfg_valid && cfg_ready)
				apply_setting(cfg_index, cfg_data);
			if (s_tvalid && s_tready)
				expected_lines.push_back(next_line_levels(s_tuser, s_tdata[31:0],
					s_tdata[37:32], s_tdata[38]));
			pending <= expected_lines.size();
		end
	end

endmodule

[dv/spi_master_shifter_unit_test.sv]
`timescale 1ns / 1ps

module spi_master_shifter_unit_test;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RX_HOLD_CYCLES = 60;
	localparam int SEGMENT_ITEMS  = 12;
	localparam int MODE_COUNT     = 16;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic [39:0] s_tdata = '0;
	logic        s_tuser = sms_pkg::REQ_TICK;
	logic        m_tready = 1'b0;
	logic        cfg_valid = 1'b0;
	logic [2:0]  cfg_index = sms_pkg::CFG_CLOCK_POLARITY;
	logic        cfg_data = 1'b0;

	wire         s_tready;
	wire         m_tvalid;
	wire  [39:0] m_tdata;
	wire         m_tlast;
	wire         cfg_ready;
	wire  [31:0] mismatch_total;
	wire  [31:0] pending_results;

	// Idle rates of both sides and the request for one long output stall.
	int          tx_idle_pct = 36;
	int          rx_idle_pct = 36;
	int          hold_token = 0;
	int          requests_sent = 0;
	int          starts_sent = 0;

	spi_master_shifter_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	spi_line_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.mismatches(mismatch_total),
		.pending(pending_results)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Offer one request, idling first at the current rate, and wait until it is taken.
	task automatic offer(input logic kind, input logic [31:0] word, input logic [5:0] count,
			input logic miso);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {1'b0, miso, count, word};
		do @(posedge clk); while (!s_tready);
		requests_sent++;
		if (kind == sms_pkg::REQ_START)
			starts_sent++;
	endtask

	task automatic tick(input logic miso);
		offer(sms_pkg::REQ_TICK, $urandom, 6'($urandom), miso);
	endtask

	// Leaves cfg_valid high; the caller lowers it after the last write.
	task automatic write_reg(input logic [2:0] idx, input logic v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic program_mode(input logic [3:0] mode);
		write_reg(sms_pkg::CFG_CLOCK_POLARITY, mode[0]);
		write_reg(sms_pkg::CFG_CLOCK_PHASE, mode[1]);
		write_reg(sms_pkg::CFG_SELECT_POLARITY, mode[2]);
		write_reg(sms_pkg::CFG_SELECT_PRESENT, ~mode[3]);
		// An index past the register list must change nothing.
		write_reg(sms_pkg::CFG_SELECT_PRESENT + 3'($urandom_range(1, 4)), 1'($urandom));
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_for_results();
		do @(posedge clk); while (pending_results != 0);
	endtask

	// One transfer with random content: mostly a start and its full set of
	// half periods, sometimes cut short, padded with idle ticks, hit by a
	// second start while busy, or preceded by one random request.
	task automatic random_transfer(input int forced_count);
		logic [5:0] count;
		int         used;
		int         n_ticks;
		int         stray_at;
		int         pick;
		int         i;
		pick = $urandom_range(0, 99);
		if (forced_count >= 0)
			count = 6'(forced_count);
		else if (pick < 5)
			count = '0;
		else if (pick < 11)
			count = 6'($urandom_range(9, 63));
		else
			count = 6'($urandom_range(1, 8));
		used = (count == 0) ? 1 :
			((count > sms_pkg::WORD_BITS) ? sms_pkg::WORD_BITS : int'(count));
		n_ticks = 2 * used;
		pick = $urandom_range(0, 99);
		if (pick < 8)
			n_ticks = $urandom_range(0, n_ticks - 1);
		else if (pick < 16)
			n_ticks += $urandom_range(1, 3);
		stray_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, n_ticks) : -1;
		if ($urandom_range(0, 19) == 0)
			offer(1'($urandom), $urandom, 6'($urandom), 1'($urandom));
		offer(sms_pkg::REQ_START, $urandom, count, 1'($urandom));
		for (i = 0; i < n_ticks; i++) begin
			if (i == stray_at)
				offer(sms_pkg::REQ_START, $urandom, 6'($urandom), 1'($urandom));
			tick(1'($urandom));
		end
	endtask

	// Output side: random back-pressure, plus one long stall on request.
	initial begin : rx_side
		int served;
		served = 0;
		forever begin
			if (served != hold_token) begin
				served = hold_token;
				m_tready <= 1'b0;
				repeat (RX_HOLD_CYCLES) @(posedge clk);
			end else begin
				m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
				@(posedge clk);
			end
		end
	end

	// Ends the run if no channel moves for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("ERROR: no channel activity for %0d cycles", WATCHDOG_LIMIT);
		$display("Simulation FAILED");
		$finish;
	end

	initial begin : stimulus
		int  seg;
		int  seg_start;
		int  i;
		bit  paused;
		paused = 1'b0;
		rx_idle_pct <= 63;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (seg = 0; seg < MODE_COUNT; seg++) begin
			// Idle rates: sender light and receiver heavy, then swapped, then none.
			if (seg == 6) begin
				tx_idle_pct = 63;
				rx_idle_pct <= 36;
			end else if (seg == 11) begin
				tx_idle_pct = 0;
				rx_idle_pct <= 0;
			end
			program_mode(seg[3:0]);

			if (seg == 0) begin
				// Tick while idle changes nothing.
				tick(1'b1);
				// Zero bit count runs as one bit; a start while busy is ignored.
				offer(sms_pkg::REQ_START, 32'hFFFF_FFFF, 6'd0, 1'b0);
				offer(sms_pkg::REQ_START, 32'h0000_0000, 6'd5, 1'b1);
				tick(1'b1);
				tick(1'b1);
				// Two bits, then a trailing tick after the end.
				offer(sms_pkg::REQ_START, 32'h0000_0002, 6'd2, 1'b0);
				tick(1'b1);
				tick(1'b0);
				tick(1'b0);
				tick(1'b1);
				tick(1'b1);
				// Only the low three bits of the word go out.
				offer(sms_pkg::REQ_START, 32'h8000_0005, 6'd3, 1'b1);
				for (i = 0; i < 6; i++)
					tick(i[0]);
			end
			if (seg == 13)
				hold_token <= hold_token + 1;

			seg_start = requests_sent;
			if (seg == 3)
				random_transfer(63);
			else if (seg == 12)
				random_transfer(sms_pkg::WORD_BITS);
			while (requests_sent - seg_start < SEGMENT_ITEMS) begin
				random_transfer(-1);
				// Once, the sender stops until every result is back.
				if (seg == 8 && !paused) begin
					paused = 1'b1;
					s_tvalid <= 1'b0;
					wait_for_results();
				end
			end
			s_tvalid <= 1'b0;
			wait_for_results();
		end

		repeat (5) @(posedge clk);
		$display("Ran %0d requests with %0d starts across all %0d clock and select settings.",
			requests_sent, starts_sent, MODE_COUNT);
		$display("Covered bit counts 0 to 63, starts while busy, idle ticks and a long stall.");
		if (mismatch_total == 0 && pending_results == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
